@@ rtl/tss_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tss_pkg
// Shared widths and types for the triangle scanline span pipeline.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int COORD_BITS = 12;
    localparam int LEN_BITS   = COORD_BITS + 1;
    localparam int NUM_BITS   = 2 * COORD_BITS;
    localparam int EXT_BITS   = COORD_BITS + 2;
    localparam int DIV_STAGES = COORD_BITS;
    localparam int COLOR_BITS = 32;

    // One edge of the triangle: start and end vertex
    typedef struct packed {
        logic [COORD_BITS-1:0] xs;
        logic [COORD_BITS-1:0] ys;
        logic [COORD_BITS-1:0] xe;
        logic [COORD_BITS-1:0] ye;
    } t_edge;

    // Sideband that travels next to the dividers
    typedef struct packed {
        logic                  on;
        logic                  flat;
        logic [COORD_BITS-1:0] flat_lo;
        logic [COORD_BITS-1:0] flat_hi;
        logic [COORD_BITS-1:0] xs_a;
        logic [COORD_BITS-1:0] xs_b;
        logic                  neg_a;
        logic                  neg_b;
        logic [COLOR_BITS-1:0] color;
    } t_side;

endpackage
`default_nettype wire

@@ rtl/triangle_scanline_span_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_scanline_span_top
// Filled span of one scanline of a triangle: start x, length and color.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled. Two 12-stage
// restoring dividers find the edge crossings; vertex sort, multiply and
// crossing add take one stage each, and the end swap feeds the last
// stage, the output register. A stall while a span is held on the
// output freezes the whole pipeline and holds the input.
module triangle_scanline_span_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [tss_pkg::COORD_BITS-1:0] i_first_x,
    input  wire logic [tss_pkg::COORD_BITS-1:0] i_first_y,
    input  wire logic [tss_pkg::COORD_BITS-1:0] i_second_x,
    input  wire logic [tss_pkg::COORD_BITS-1:0] i_second_y,
    input  wire logic [tss_pkg::COORD_BITS-1:0] i_third_x,
    input  wire logic [tss_pkg::COORD_BITS-1:0] i_third_y,
    input  wire logic [tss_pkg::COORD_BITS-1:0] i_scan_y,
    input  wire logic [tss_pkg::COLOR_BITS-1:0] i_fill_color,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_on_span,
    output logic      [tss_pkg::COORD_BITS-1:0] o_span_start,
    output logic      [tss_pkg::LEN_BITS-1:0]   o_span_length,
    output logic      [tss_pkg::COLOR_BITS-1:0] o_span_color
);
    import tss_pkg::*;

    logic w_en;

    // Sort stage
    logic [COORD_BITS-1:0] vx [0:2];
    logic [COORD_BITS-1:0] vy [0:2];
    logic [1:0]            top, p, q, i1, i2;
    logic [COORD_BITS-1:0] x0, y0, x1, y1, x2, y2;
    logic signed [COORD_BITS:0] last, sy_s;
    logic                  upper, lower;
    logic [COORD_BITS-1:0] lo01, hi01;
    t_side                 n_s1_side;
    t_edge                 n_s1_ea, n_s1_eb;

    logic                  r_s1_valid;
    t_side                 r_s1_side;
    t_edge                 r_s1_ea, r_s1_eb;
    logic [COORD_BITS-1:0] r_s1_sy;

    // Multiply stage
    logic signed [COORD_BITS:0]     dx_a, dx_b;
    logic [COORD_BITS-1:0]          dt_a, dt_b;
    logic signed [NUM_BITS+1:0]     prod_a, prod_b;
    logic signed [NUM_BITS+1:0]     mag_a, mag_b;
    t_side                          n_s2_side;

    logic                  r_s2_valid;
    t_side                 r_s2_side;
    logic [NUM_BITS-1:0]   r_s2_num_a, r_s2_num_b;
    logic [COORD_BITS-1:0] r_s2_den_a, r_s2_den_b;

    // Divide stages
    logic                  r_dv_valid [0:DIV_STAGES-1];
    t_side                 r_dv_side  [0:DIV_STAGES-1];
    logic [COORD_BITS-1:0] w_quo_a, w_quo_b;

    // Crossing stage
    logic signed [EXT_BITS-1:0] n_f_a, n_f_b;
    logic                       r_f_valid;
    logic                       r_f_on;
    logic [COLOR_BITS-1:0]      r_f_color;
    logic signed [EXT_BITS-1:0] r_f_a, r_f_b;

    // Output stage
    logic signed [EXT_BITS-1:0] lo, hi, len;
    logic                       r_o_valid;
    logic                       r_o_on;
    logic [COORD_BITS-1:0]      r_o_start;
    logic [LEN_BITS-1:0]        r_o_len;
    logic [COLOR_BITS-1:0]      r_o_color;

    // Advance the whole pipeline unless a finished span is held
    assign w_en    = !(r_o_valid && i_stall);
    assign o_stall = !w_en;

    // Order vertices by y and pick the edges that cross this scanline
    always_comb begin
        vx[0] = i_first_x;  vy[0] = i_first_y;
        vx[1] = i_second_x; vy[1] = i_second_y;
        vx[2] = i_third_x;  vy[2] = i_third_y;
        top = 2'd0;
        if (vy[1] < vy[0]) top = 2'd1;
        if (vy[2] < vy[top]) top = 2'd2;
        p = (top == 2'd0) ? 2'd1 : 2'd0;
        q = (top == 2'd2) ? 2'd1 : 2'd2;
        if (vy[p] < vy[q]) begin
            i1 = p; i2 = q;
        end else begin
            i1 = q; i2 = p;
        end
        x0 = vx[top]; y0 = vy[top];
        x1 = vx[i1];  y1 = vy[i1];
        x2 = vx[i2];  y2 = vy[i2];
        sy_s  = $signed({1'b0, i_scan_y});
        last  = (y1 == y2) ? $signed({1'b0, y1})
                           : ($signed({1'b0, y1}) - $signed((COORD_BITS+1)'(1)));
        upper = (i_scan_y >= y0) && (sy_s <= last);
        lower = (sy_s > last) && (i_scan_y <= y2);
        lo01  = (x1 < x0) ? x1 : x0;
        hi01  = (x1 > x0) ? x1 : x0;
        n_s1_side         = '0;
        n_s1_side.flat    = (y0 == y2);
        n_s1_side.on      = (y0 == y2) ? (i_scan_y == y0) : (upper || lower);
        n_s1_side.flat_lo = (x2 < lo01) ? x2 : lo01;
        n_s1_side.flat_hi = (x2 > hi01) ? x2 : hi01;
        n_s1_side.color   = i_fill_color;
        if (upper) begin
            n_s1_ea.xs = x0; n_s1_ea.ys = y0; n_s1_ea.xe = x1; n_s1_ea.ye = y1;
        end else begin
            n_s1_ea.xs = x1; n_s1_ea.ys = y1; n_s1_ea.xe = x2; n_s1_ea.ye = y2;
        end
        n_s1_eb.xs = x0; n_s1_eb.ys = y0; n_s1_eb.xe = x2; n_s1_eb.ye = y2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_side <= n_s1_side;
            r_s1_ea   <= n_s1_ea;
            r_s1_eb   <= n_s1_eb;
            r_s1_sy   <= i_scan_y;
        end
    end

    // Form dx * (y - ys) as sign and magnitude
    always_comb begin
        dx_a   = $signed({1'b0, r_s1_ea.xe}) - $signed({1'b0, r_s1_ea.xs});
        dx_b   = $signed({1'b0, r_s1_eb.xe}) - $signed({1'b0, r_s1_eb.xs});
        dt_a   = r_s1_sy - r_s1_ea.ys;
        dt_b   = r_s1_sy - r_s1_eb.ys;
        prod_a = (NUM_BITS+2)'(dx_a) * (NUM_BITS+2)'($signed({1'b0, dt_a}));
        prod_b = (NUM_BITS+2)'(dx_b) * (NUM_BITS+2)'($signed({1'b0, dt_b}));
        mag_a  = prod_a[NUM_BITS+1] ? -prod_a : prod_a;
        mag_b  = prod_b[NUM_BITS+1] ? -prod_b : prod_b;
        n_s2_side       = r_s1_side;
        n_s2_side.xs_a  = r_s1_ea.xs;
        n_s2_side.xs_b  = r_s1_eb.xs;
        n_s2_side.neg_a = prod_a[NUM_BITS+1];
        n_s2_side.neg_b = prod_b[NUM_BITS+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_side  <= n_s2_side;
            r_s2_num_a <= mag_a[NUM_BITS-1:0];
            r_s2_num_b <= mag_b[NUM_BITS-1:0];
            r_s2_den_a <= r_s1_ea.ye - r_s1_ea.ys;
            r_s2_den_b <= r_s1_eb.ye - r_s1_eb.ys;
        end
    end

    // Divide both edges in parallel
    tss_div_pipe u_div_a (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s2_num_a),
        .i_den (r_s2_den_a),
        .o_quo (w_quo_a)
    );

    tss_div_pipe u_div_b (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s2_num_b),
        .i_den (r_s2_den_b),
        .o_quo (w_quo_b)
    );

    // Carry valid and sideband alongside the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) r_dv_valid[k] <= 1'b0;
        end else if (w_en) begin
            r_dv_valid[0] <= r_s2_valid;
            for (int k = 1; k < DIV_STAGES; k++) r_dv_valid[k] <= r_dv_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_side[0] <= r_s2_side;
            for (int k = 1; k < DIV_STAGES; k++) r_dv_side[k] <= r_dv_side[k-1];
        end
    end

    // Add the signed quotient to the edge start x, or take the flat extremes
    always_comb begin
        if (r_dv_side[DIV_STAGES-1].flat) begin
            n_f_a = $signed({2'b00, r_dv_side[DIV_STAGES-1].flat_lo});
            n_f_b = $signed({2'b00, r_dv_side[DIV_STAGES-1].flat_hi});
        end else begin
            n_f_a = $signed({2'b00, r_dv_side[DIV_STAGES-1].xs_a})
                  + (r_dv_side[DIV_STAGES-1].neg_a ? -$signed({2'b00, w_quo_a})
                                                   :  $signed({2'b00, w_quo_a}));
            n_f_b = $signed({2'b00, r_dv_side[DIV_STAGES-1].xs_b})
                  + (r_dv_side[DIV_STAGES-1].neg_b ? -$signed({2'b00, w_quo_b})
                                                   :  $signed({2'b00, w_quo_b}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_en) begin
            r_f_valid <= r_dv_valid[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_on    <= r_dv_side[DIV_STAGES-1].on;
            r_f_color <= r_dv_side[DIV_STAGES-1].color;
            r_f_a     <= n_f_a;
            r_f_b     <= n_f_b;
        end
    end

    // Order the ends and measure the span
    always_comb begin
        lo  = (r_f_a > r_f_b) ? r_f_b : r_f_a;
        hi  = (r_f_a > r_f_b) ? r_f_a : r_f_b;
        len = hi - lo + $signed(EXT_BITS'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_on    <= r_f_on;
            r_o_start <= r_f_on ? lo[COORD_BITS-1:0] : '0;
            r_o_len   <= r_f_on ? len[LEN_BITS-1:0] : '0;
            r_o_color <= r_f_color;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_on_span     = r_o_on;
    assign o_span_start  = r_o_start;
    assign o_span_length = r_o_len;
    assign o_span_color  = r_o_color;

    // Input stalls exactly when a finished span is held
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow held output");

    // An empty scanline reports zero start and length
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_on_span) |-> (o_span_start == '0 && o_span_length == '0))
        else $error("empty span carries nonzero start or length");

    // A covered scanline holds at least one pixel
    a_span_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_on_span) |-> (o_span_length != '0))
        else $error("covered scanline with zero length");

endmodule
`default_nettype wire

@@ rtl/tss_div_pipe.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tss_div_pipe
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit in COORD_BITS bits.
// ----------------------------------------------------------------------------
module tss_div_pipe (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [tss_pkg::NUM_BITS-1:0]   i_num,
    input  wire logic [tss_pkg::COORD_BITS-1:0] i_den,
    output logic      [tss_pkg::COORD_BITS-1:0] o_quo
);
    import tss_pkg::*;

    logic [NUM_BITS-1:0]   s_rem [0:DIV_STAGES];
    logic [COORD_BITS-1:0] s_den [0:DIV_STAGES];
    logic [COORD_BITS-1:0] s_quo [0:DIV_STAGES];

    assign s_rem[0] = i_num;
    assign s_den[0] = i_den;
    assign s_quo[0] = '0;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        localparam int BIT = DIV_STAGES - 1 - k;
        logic [NUM_BITS-1:0]   w_trial;
        logic                  w_ge;
        logic [NUM_BITS-1:0]   r_rem;
        logic [COORD_BITS-1:0] r_den;
        logic [COORD_BITS-1:0] r_quo;

        // Try the shifted divisor against the remainder
        assign w_trial = NUM_BITS'(s_den[k]) << BIT;
        assign w_ge    = (s_rem[k] >= w_trial);

        // Advance one quotient bit
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= w_ge ? (s_rem[k] - w_trial) : s_rem[k];
                r_den <= s_den[k];
                r_quo <= s_quo[k] | (COORD_BITS'(w_ge) << BIT);
            end
        end

        assign s_rem[k+1] = r_rem;
        assign s_den[k+1] = r_den;
        assign s_quo[k+1] = r_quo;
    end

    assign o_quo = s_quo[DIV_STAGES];

endmodule
`default_nettype wire

@@ test/tb_triangle_scanline_span_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_triangle_scanline_span_top
// Self-checking bench for the triangle scanline span pipeline.
// ----------------------------------------------------------------------------
// A driver feeds triangle/scanline items from a queue with random idle
// cycles; a monitor compares every output transfer with the span that a
// behavioral predictor computed when the item was accepted. The receiver
// stalls at random and once holds off long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module tb_triangle_scanline_span_top;
    import tss_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 3 * (COORD_BITS + 4);

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord                fx, fy, sx, sy, tx, ty, scan;
        logic [COLOR_BITS-1:0] color;
    } t_item;

    typedef struct packed {
        logic                  on;
        t_coord                start;
        logic [LEN_BITS-1:0]   length;
        logic [COLOR_BITS-1:0] color;
    } t_span;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_coord                i_first_x, i_first_y, i_second_x, i_second_y;
    t_coord                i_third_x, i_third_y, i_scan_y;
    logic [COLOR_BITS-1:0] i_fill_color;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_on_span;
    t_coord                o_span_start;
    logic [LEN_BITS-1:0]   o_span_length;
    logic [COLOR_BITS-1:0] o_span_color;

    t_item  pending_items[$];
    t_span  expected_spans[$];
    int     error_count = 0;
    int     cycle_count = 0;
    int     hold_off_left;
    bit     stim_done;
    bit     calm_phase = 1'b0;

    triangle_scanline_span_top DUT (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Edge crossing with division truncating toward zero
    function automatic longint cross_x(longint xs, longint ys, longint xe, longint ye,
                                       longint y);
        return xs + ((xe - xs) * (y - ys)) / (ye - ys);
    endfunction

    // Compute the expected span of one item
    function automatic t_span predict_span(t_item it);
        longint vx[3], vy[3];
        longint x0, y0, x1, y1, x2, y2, a, b, last, t, sy;
        int top, p, q, i1, i2;
        bit on;
        t_span s;
        vx[0] = longint'(it.fx); vy[0] = longint'(it.fy);
        vx[1] = longint'(it.sx); vy[1] = longint'(it.sy);
        vx[2] = longint'(it.tx); vy[2] = longint'(it.ty);
        sy = longint'(it.scan);
        on = 1'b0;
        a = 0;
        b = 0;
        top = 0;
        if (vy[1] < vy[top]) top = 1;
        if (vy[2] < vy[top]) top = 2;
        p = (top == 0) ? 1 : 0;
        q = (top == 2) ? 1 : 2;
        if (vy[p] < vy[q]) begin
            i1 = p; i2 = q;
        end else begin
            i1 = q; i2 = p;
        end
        x0 = vx[top]; y0 = vy[top];
        x1 = vx[i1];  y1 = vy[i1];
        x2 = vx[i2];  y2 = vy[i2];
        if (y0 == y2) begin
            if (sy == y0) begin
                on = 1'b1;
                a = x0; b = x0;
                if (x1 < a) a = x1;
                if (x1 > b) b = x1;
                if (x2 < a) a = x2;
                if (x2 > b) b = x2;
            end
        end else begin
            last = (y1 == y2) ? y1 : y1 - 1;
            if (sy >= y0 && sy <= last) begin
                on = 1'b1;
                a = cross_x(x0, y0, x1, y1, sy);
                b = cross_x(x0, y0, x2, y2, sy);
            end else if (sy > last && sy <= y2) begin
                on = 1'b1;
                a = cross_x(x1, y1, x2, y2, sy);
                b = cross_x(x0, y0, x2, y2, sy);
            end
            if (on && a > b) begin
                t = a; a = b; b = t;
            end
        end
        s.on     = on;
        s.start  = on ? t_coord'(a) : '0;
        s.length = on ? LEN_BITS'(b - a + 1) : '0;
        s.color  = it.color;
        return s;
    endfunction

    function automatic t_item make_item(int fx, int fy, int sx, int sy, int tx, int ty,
                                        int scan);
        t_item it;
        it.fx = t_coord'(fx); it.fy = t_coord'(fy); it.sx = t_coord'(sx);
        it.sy = t_coord'(sy); it.tx = t_coord'(tx); it.ty = t_coord'(ty);
        it.scan = t_coord'(scan);
        it.color = $urandom();
        return it;
    endfunction

    // Random triangle with a scanline mostly inside its y range
    function automatic t_item random_item();
        t_item it;
        int span_sel, lo, hi, m;
        span_sel = int'($urandom_range(0, 9));
        m = (span_sel < 6) ? 63 : 4095;
        lo = int'($urandom_range(0, 4095 - m));
        it.fx = t_coord'($urandom_range(0, 4095));
        it.sx = t_coord'($urandom_range(0, 4095));
        it.tx = t_coord'($urandom_range(0, 4095));
        it.fy = t_coord'(lo + int'($urandom_range(0, m)));
        it.sy = ($urandom_range(0, 7) == 0) ? it.fy
                                            : t_coord'(lo + int'($urandom_range(0, m)));
        it.ty = ($urandom_range(0, 7) == 0) ? it.sy
                                            : t_coord'(lo + int'($urandom_range(0, m)));
        lo = int'(it.fy); hi = int'(it.fy);
        if (int'(it.sy) < lo) lo = int'(it.sy);
        if (int'(it.ty) < lo) lo = int'(it.ty);
        if (int'(it.sy) > hi) hi = int'(it.sy);
        if (int'(it.ty) > hi) hi = int'(it.ty);
        if ($urandom_range(0, 9) < 8) begin
            it.scan = t_coord'($urandom_range(lo, hi));
        end else begin
            it.scan = t_coord'($urandom_range(0, 4095));
        end
        it.color = $urandom();
        return it;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("span %0s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Fill the item queue: directed corners first, then random triangles
    initial begin
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(4095, 4095, 4095, 4095, 4095, 4095, 4095));
        pending_items.push_back(make_item(0, 0, 4095, 0, 2048, 0, 0));
        pending_items.push_back(make_item(0, 7, 4095, 7, 2048, 7, 8));
        pending_items.push_back(make_item(0, 0, 4095, 0, 2048, 4095, 100));
        pending_items.push_back(make_item(0, 0, 4095, 0, 2048, 4095, 4095));
        pending_items.push_back(make_item(2048, 0, 0, 4095, 4095, 4095, 4095));
        pending_items.push_back(make_item(2048, 0, 0, 4095, 4095, 4095, 0));
        pending_items.push_back(make_item(2048, 0, 0, 4095, 4095, 4095, 3000));
        pending_items.push_back(make_item(0, 4095, 4095, 0, 4095, 2000, 1999));
        pending_items.push_back(make_item(0, 4095, 4095, 0, 4095, 2000, 2000));
        pending_items.push_back(make_item(4095, 10, 0, 20, 4095, 30, 25));
        pending_items.push_back(make_item(10, 50, 20, 50, 30, 50, 50));
        pending_items.push_back(make_item(10, 50, 20, 40, 30, 40, 40));
        pending_items.push_back(make_item(10, 30, 20, 40, 30, 50, 29));
        pending_items.push_back(make_item(10, 30, 20, 40, 30, 50, 51));
        pending_items.push_back(make_item(4095, 0, 0, 1, 4095, 4095, 2));
        pending_items.push_back(make_item(1365, 2730, 2730, 1365, 4095, 0, 1365));
        pending_items.push_back(make_item(100, 5, 200, 5, 150, 3, 5));
        repeat (500) pending_items.push_back(random_item());
    end

    // Reset, stimulus end, drain and verdict
    initial begin
        i_rst_n = 1'b0;
        stim_done = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0 && !i_valid);
        wait (expected_spans.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        stim_done = 1'b1;
        if (error_count == 0 && expected_spans.size() == 0) begin
            $display("triangle_scanline_span_top: match");
        end else begin
            $display("triangle_scanline_span_top: mismatch");
        end
        $finish;
    end

    // Cycle counter and timeout; idling and random receiver stalls pause in recurring calm stretches
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        calm_phase  <= ((cycle_count % 4000) >= 300) && ((cycle_count % 4000) < 600);
        if (cycle_count > LIMIT_CYCLES && !stim_done) begin
            $display("triangle_scanline_span_top: mismatch");
            $finish;
        end
    end

    // Driver: present the next item, hold it while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid      <= 1'b0;
            i_first_x    <= '0; i_first_y  <= '0;
            i_second_x   <= '0; i_second_y <= '0;
            i_third_x    <= '0; i_third_y  <= '0;
            i_scan_y     <= '0;
            i_fill_color <= '0;
        end else if (!i_valid || !o_stall) begin
            if (pending_items.size() != 0 && (calm_phase || $urandom_range(0, 99) >= 18))
                begin
                t_item it;
                it = pending_items.pop_front();
                i_first_x  <= it.fx; i_first_y  <= it.fy;
                i_second_x <= it.sx; i_second_y <= it.sy;
                i_third_x  <= it.tx; i_third_y  <= it.ty;
                i_scan_y   <= it.scan;
                i_fill_color <= it.color;
                i_valid    <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Record the expected span of each input transfer
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            expected_spans.push_back(predict_span('{i_first_x, i_first_y, i_second_x,
                i_second_y, i_third_x, i_third_y, i_scan_y, i_fill_color}));
        end
    end

    // Receiver stall, with one long hold-off early in the run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_off_left <= 0;
        end else if (cycle_count == 200) begin
            hold_off_left <= 120;
            i_stall <= 1'b1;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm_phase && ($urandom_range(0, 99) < 18);
        end
    end

    // Monitor: compare each output transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_spans.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                t_span s;
                s = expected_spans.pop_front();
                if (o_on_span !== s.on) report_mismatch("on", o_on_span, s.on);
                if (o_span_start !== s.start)
                    report_mismatch("start", o_span_start, s.start);
                if (o_span_length !== s.length)
                    report_mismatch("length", o_span_length, s.length);
                if (o_span_color !== s.color)
                    report_mismatch("color", o_span_color, s.color);
            end
        end
    end

endmodule
`default_nettype wire
